// File: sv/csld_pkg.sv
`timescale 1ns / 1ps
package csld_pkg;
   localparam int SLOTS = 16;
   localparam int SN_W = 4;
   localparam int MAX_LEN_BYTES = 2;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_POLL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_UNDEF = 2'd3;

   localparam logic [2:0] EV_OPEN   = 3'd0;
   localparam logic [2:0] EV_STATE  = 3'd1;
   localparam logic [2:0] EV_AHDR   = 3'd2;
   localparam logic [2:0] EV_ABYTE  = 3'd3;
   localparam logic [2:0] EV_CLOSE  = 3'd4;
   localparam logic [2:0] EV_ERROR  = 3'd5;
   localparam logic [2:0] EV_IDLE   = 3'd6;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_SN   = 3'd1;
   localparam logic [2:0] ERR_CLOSED   = 3'd2;
   localparam logic [2:0] ERR_TAG      = 3'd3;
   localparam logic [2:0] ERR_LEN      = 3'd4;
   localparam logic [2:0] ERR_LONG_LEN = 3'd5;

   localparam logic [7:0] TAG_DATA   = 8'h90;
   localparam logic [7:0] TAG_OPEN   = 8'h91;
   localparam logic [7:0] TAG_CREATE = 8'h94;
   localparam logic [7:0] TAG_CLOSE  = 8'h95;
   localparam logic [7:0] TAG_CLOSE_RSP = 8'h96;
   localparam logic [7:0] ST_FULL    = 8'hF3;
   localparam logic [7:0] ST_UNKNOWN = 8'hF0;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  session_number;
      logic [7:0]  status;
      logic [31:0] value;
      logic [15:0] apdu_length;
      logic [1:0]  session_state;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // request as seen by the back part
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] total_length;
   } req_type;

   function automatic logic known_resource(input logic [31:0] id);
      return id == 32'h00010041 || id == 32'h00020041 || id == 32'h00030041 ||
             id == 32'h00240041 || id == 32'h00400041;
   endfunction
endpackage

// File: sv/csld_front.sv
`timescale 1ns / 1ps
// input stage: registers requests and drops those that cause nothing
module csld_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first_byte,
   input  logic [15:0]         req_total_length,
   output logic                q_valid,
   input  logic                q_stall,
   output csld_pkg::req_type   q_data
);
   // two-entry queue
   csld_pkg::req_type mem_ff [2];
   csld_pkg::req_type mem_in [2];
   logic [1:0] count_ff, count_in;
   logic       acc, pop;
   csld_pkg::req_type r;

   assign req_stall = count_ff == 2'd2;
   assign acc = req_valid && !req_stall && req_opcode != csld_pkg::OP_UNDEF;
   assign q_valid = count_ff != 2'd0;
   assign q_data = mem_ff[0];
   assign pop = q_valid && !q_stall;

   always_comb begin
      r.opcode = req_opcode;
      r.data_byte = req_data_byte;
      r.first_byte = req_first_byte;
      r.total_length = req_total_length;
      mem_in = mem_ff;
      count_in = count_ff;
      if (pop) begin
         mem_in[0] = mem_ff[1];
         count_in = count_in - 2'd1;
      end
      if (acc) begin
         mem_in[count_in[0]] = r;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      mem_ff <= mem_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> req_stall) else $error("full queue not stalling");
   a_pop_drop: assert property (@(posedge clock) disable iff (reset)
      pop && !acc |=> count_ff == $past(count_ff) - 2'd1) else $error("count slip");
endmodule

// File: sv/csld_back.sv
`timescale 1ns / 1ps
// parser and session table; one request per cycle while its three-result output buffer has room
module csld_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_stall,
   input  csld_pkg::req_type  q_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csld_pkg::rsp_type  rsp_data
);
   typedef enum logic [3:0] {
      PH_WAIT, PH_LEN, PH_LEN_MORE, PH_BODY, PH_ATAG, PH_ALEN, PH_ALEN_MORE,
      PH_ABODY, PH_DISCARD
   } phase_type;

   localparam int S = csld_pkg::SLOTS;

   phase_type   phase_ff, phase_in;
   logic [7:0]  ptag_ff, ptag_in;
   logic [15:0] lacc_ff, lacc_in;
   logic [6:0]  lleft_ff, lleft_in;
   logic [15:0] bcnt_ff, bcnt_in;
   logic [31:0] hsh_ff, hsh_in;
   logic [15:0] brem_ff, brem_in;
   logic [23:0] atag_ff, atag_in;
   logic [15:0] aleft_ff, aleft_in;
   logic [3:0]  cur_ff, cur_in;
   logic [S-1:0] sv_ff, sv_in;
   logic [1:0]  sph_ff [S], sph_in [S];
   logic [7:0]  sst_ff [S], sst_in [S];

   // output buffer of up to three results
   csld_pkg::rsp_type ob_ff [3], ob_in [3];
   logic [1:0] oc_ff, oc_in;

   csld_pkg::rsp_type res [2];
   logic [1:0] nres;
   logic       go;

   assign q_stall = oc_ff > 2'd1;
   assign go = q_valid && !q_stall;
   assign rsp_valid = oc_ff != 2'd0;
   assign rsp_data = ob_ff[0];

   function automatic csld_pkg::rsp_type mk(input logic [2:0] ev, input logic [3:0] sn,
         input logic [7:0] st, input logic [31:0] val, input logic [15:0] al,
         input logic [1:0] ss, input logic [2:0] er);
      csld_pkg::rsp_type x;
      x.event_res = ev; x.session_number = sn; x.status = st; x.value = val;
      x.apdu_length = al; x.session_state = ss; x.error_code = er; x.last = 1'b0;
      return x;
   endfunction

   always_comb begin
      logic [7:0] b;
      logic [1:0] lr;
      logic       deciding;
      logic [3:0] fi, pi;
      logic       ffound, pfound;
      logic [15:0] sn16;
      logic [3:0] sn;
      logic [15:0] alen;
      logic [1:0] cst;
      logic       clean;
      phase_type  more;
      phase_in = phase_ff; ptag_in = ptag_ff; lacc_in = lacc_ff; lleft_in = lleft_ff;
      bcnt_in = bcnt_ff; hsh_in = hsh_ff; brem_in = brem_ff; atag_in = atag_ff;
      aleft_in = aleft_ff; cur_in = cur_ff; sv_in = sv_ff; sph_in = sph_ff;
      sst_in = sst_ff;
      res[0] = '0; res[1] = '0; nres = 2'd0;
      b = q_data.data_byte; lr = 2'd0; deciding = 1'b0; more = PH_LEN_MORE;
      fi = '0; ffound = 1'b0; pi = '0; pfound = 1'b0;
      sn16 = '0; sn = '0; alen = '0; clean = 1'b0;
      cst = (cur_ff == 4'd0) ? 2'd0 : sph_ff[cur_ff - 4'd1];
      // first free and first pending-close entries, priority encoded
      for (int i = S - 2; i >= 0; i--) begin
         if (!sv_ff[i]) begin fi = 4'(i); ffound = 1'b1; end
         if (sv_ff[i] && sph_ff[i] == 2'd2) begin pi = 4'(i); pfound = 1'b1; end
      end
      if (go) begin
         case (q_data.opcode)
            csld_pkg::OP_POLL: begin
               if (pfound) begin
                  sv_in[pi] = 1'b0; sph_in[pi] = 2'd0; sst_in[pi] = 8'd0;
                  res[0] = mk(csld_pkg::EV_CLOSE, pi + 4'd1, 8'd0,
                     {24'd0, csld_pkg::TAG_CLOSE_RSP}, 16'd0, 2'd2, csld_pkg::ERR_NONE);
               end else begin
                  res[0] = mk(csld_pkg::EV_IDLE, 4'd0, 8'd0, 32'd0, 16'd0, 2'd0,
                     csld_pkg::ERR_NONE);
               end
               nres = 2'd1;
            end
            csld_pkg::OP_CLEAR: begin
               sv_in = '0;
               for (int i = 0; i < S; i++) begin sph_in[i] = 2'd0; sst_in[i] = 8'd0; end
               phase_in = PH_WAIT; cur_in = '0;
               res[0] = mk(csld_pkg::EV_IDLE, 4'd0, 8'd0, 32'd0, 16'd0, 2'd0,
                  csld_pkg::ERR_NONE);
               nres = 2'd1;
            end
            csld_pkg::OP_BYTE: begin
               if (q_data.first_byte) begin
                  ptag_in = b;
                  brem_in = (q_data.total_length != 16'd0) ?
                     q_data.total_length - 16'd1 : 16'd0;
                  phase_in = PH_LEN; hsh_in = '0; bcnt_in = '0; atag_in = '0;
                  lacc_in = '0; lleft_in = '0;
               end else if (phase_ff != PH_WAIT) begin
                  if (brem_ff != 16'd0) brem_in = brem_ff - 16'd1;
                  if (phase_ff == PH_ALEN || phase_ff == PH_ALEN_MORE) more = PH_ALEN_MORE;
                  if (phase_ff == PH_LEN || phase_ff == PH_LEN_MORE ||
                      phase_ff == PH_ALEN || phase_ff == PH_ALEN_MORE) begin
                     if (phase_ff == more) begin
                        lacc_in = (lacc_ff > 16'hFF) ? 16'hFFFF : {lacc_ff[7:0], b};
                        lleft_in = lleft_ff - 7'd1;
                        lr = (lleft_in == 7'd0) ? 2'd1 : 2'd0;
                     end else begin
                        lacc_in = '0;
                        if (!b[7]) begin lacc_in = {8'd0, b}; lr = 2'd1; end
                        else if (b[6:0] > 7'(csld_pkg::MAX_LEN_BYTES)) lr = 2'd2;
                        else if (b[6:0] == 7'd0) lr = 2'd1;
                        else begin lleft_in = b[6:0]; phase_in = more; end
                     end
                  end
                  case (phase_ff)
                     PH_LEN, PH_LEN_MORE: begin
                        if (lr == 2'd2) begin
                           phase_in = PH_DISCARD;
                           res[0] = mk(csld_pkg::EV_ERROR, 4'd0, 8'd0, 32'd0, 16'd0,
                              2'd0, csld_pkg::ERR_LONG_LEN);
                           nres = 2'd1;
                        end else if (lr == 2'd1) begin
                           bcnt_in = '0; hsh_in = '0; atag_in = '0;
                           if (lacc_in == 16'd0) deciding = 1'b1;
                           else phase_in = PH_BODY;
                        end
                     end
                     PH_BODY: begin
                        if (bcnt_ff == 16'd0) atag_in = {16'd0, b};
                        if (ptag_ff == csld_pkg::TAG_OPEN) begin
                           case (bcnt_ff)
                              16'd0: hsh_in[31:24] = hsh_ff[31:24] | b;
                              16'd1: hsh_in[23:16] = hsh_ff[23:16] | b;
                              16'd2: hsh_in[15:8] = hsh_ff[15:8] | b;
                              16'd3: hsh_in[7:0] = hsh_ff[7:0] | b;
                              default: hsh_in = hsh_ff;
                           endcase
                        end else begin
                           hsh_in = {hsh_ff[23:0], b};
                        end
                        bcnt_in = bcnt_ff + 16'd1;
                        if (bcnt_in == lacc_ff) deciding = 1'b1;
                     end
                     PH_ATAG: begin
                        atag_in = {atag_ff[15:0], b};
                        bcnt_in = bcnt_ff + 16'd1;
                        if (bcnt_in >= 16'd3) begin phase_in = PH_ALEN; lacc_in = '0; end
                     end
                     PH_ALEN, PH_ALEN_MORE: begin
                        if (lr == 2'd2) begin
                           phase_in = PH_DISCARD;
                           res[0] = mk(csld_pkg::EV_ERROR, cur_ff, 8'd0, 32'd0, 16'd0,
                              cst, csld_pkg::ERR_LONG_LEN);
                           nres = 2'd1;
                        end else if (lr == 2'd1) begin
                           alen = lacc_in;
                           if (brem_in > alen && brem_in - alen < 16'd3) alen = brem_in;
                           res[0] = mk(csld_pkg::EV_AHDR, cur_ff, 8'd0, {8'd0, atag_ff},
                              alen, cst, csld_pkg::ERR_NONE);
                           nres = 2'd1;
                           aleft_in = alen;
                           if (alen == 16'd0) begin
                              phase_in = PH_ATAG; atag_in = '0; bcnt_in = '0;
                           end else phase_in = PH_ABODY;
                        end
                     end
                     PH_ABODY: begin
                        res[0] = mk(csld_pkg::EV_ABYTE, cur_ff, 8'd0, {24'd0, b}, 16'd0,
                           cst, csld_pkg::ERR_NONE);
                        nres = 2'd1;
                        aleft_in = aleft_ff - 16'd1;
                        if (aleft_in == 16'd0) begin
                           phase_in = PH_ATAG; atag_in = '0; bcnt_in = '0;
                        end
                     end
                     default: ;
                  endcase
                  if (deciding) begin
                     if (ptag_ff == csld_pkg::TAG_OPEN) begin
                        if (ffound && csld_pkg::known_resource(hsh_in)) begin
                           sv_in[fi] = 1'b1; sph_in[fi] = 2'd1; sst_in[fi] = 8'd0;
                           res[0] = mk(csld_pkg::EV_OPEN, fi + 4'd1, 8'd0, hsh_in, 16'd0,
                              2'd1, csld_pkg::ERR_NONE);
                           cur_in = fi + 4'd1;
                           phase_in = PH_ATAG; atag_in = '0; bcnt_in = '0;
                           nres = 2'd1;
                        end else begin
                           res[0] = mk(csld_pkg::EV_OPEN, 4'd0,
                              ffound ? csld_pkg::ST_UNKNOWN : csld_pkg::ST_FULL, hsh_in,
                              16'd0, 2'd0, csld_pkg::ERR_NONE);
                           nres = 2'd1;
                           if (brem_in != 16'd0) begin
                              res[1] = mk(csld_pkg::EV_ERROR, 4'd0, 8'd0, 32'd0, 16'd0,
                                 2'd0, csld_pkg::ERR_LEN);
                              nres = 2'd2;
                           end
                           phase_in = PH_DISCARD;
                        end
                     end else begin
                        sn16 = hsh_in[15:0];
                        sn = sn16[3:0];
                        if (sn16 == 16'd0 || sn16 >= 16'(S)) begin
                           phase_in = PH_DISCARD;
                           res[0] = mk(csld_pkg::EV_ERROR, 4'd0, 8'd0, 32'd0, 16'd0, 2'd0,
                              csld_pkg::ERR_BAD_SN);
                           nres = 2'd1;
                        end else if (!sv_ff[sn - 4'd1]) begin
                           phase_in = PH_DISCARD;
                           res[0] = mk(csld_pkg::EV_ERROR, sn, 8'd0, 32'd0, 16'd0, 2'd0,
                              csld_pkg::ERR_CLOSED);
                           nres = 2'd1;
                        end else if (ptag_ff != csld_pkg::TAG_CREATE &&
                                     ptag_ff != csld_pkg::TAG_CLOSE &&
                                     ptag_ff != csld_pkg::TAG_DATA) begin
                           phase_in = PH_DISCARD;
                           res[0] = mk(csld_pkg::EV_ERROR, sn, 8'd0, 32'd0, 16'd0, 2'd0,
                              csld_pkg::ERR_TAG);
                           nres = 2'd1;
                        end else begin
                           if (ptag_ff == csld_pkg::TAG_CREATE) begin
                              sst_in[sn - 4'd1] = atag_in[7:0];
                              sph_in[sn - 4'd1] = 2'd1;
                              res[0] = mk(csld_pkg::EV_STATE, sn, atag_in[7:0], 32'd0,
                                 16'd0, 2'd1, csld_pkg::ERR_NONE);
                              nres = 2'd1;
                           end else if (ptag_ff == csld_pkg::TAG_CLOSE) begin
                              sph_in[sn - 4'd1] = 2'd2;
                              res[0] = mk(csld_pkg::EV_STATE, sn, sst_ff[sn - 4'd1], 32'd0,
                                 16'd0, 2'd2, csld_pkg::ERR_NONE);
                              nres = 2'd1;
                           end
                           cur_in = sn;
                           phase_in = PH_ATAG; atag_in = '0; bcnt_in = '0;
                        end
                     end
                  end
               end
               if (phase_in != PH_WAIT && brem_in == 16'd0 &&
                   (q_data.first_byte || phase_ff != PH_WAIT)) begin
                  clean = phase_in == PH_DISCARD || (phase_in == PH_ATAG && bcnt_in == 16'd0);
                  if (!clean) begin
                     res[nres[0]] = mk(csld_pkg::EV_ERROR, 4'd0, 8'd0, 32'd0, 16'd0,
                        2'd0, csld_pkg::ERR_LEN);
                     nres = nres + 2'd1;
                  end
                  phase_in = PH_WAIT;
               end
            end
            default: ;
         endcase
         if (nres != 2'd0) res[nres[1] ? 1 : 0].last = 1'b1;
      end
      // output buffer: pop front, append new results
      ob_in = ob_ff;
      oc_in = oc_ff;
      if (rsp_valid && !rsp_stall) begin
         ob_in[0] = ob_ff[1]; ob_in[1] = ob_ff[2]; oc_in = oc_ff - 2'd1;
      end
      if (nres != 2'd0) begin
         ob_in[oc_in] = res[0];
         if (nres == 2'd2) ob_in[oc_in + 2'd1] = res[1];
         oc_in = oc_in + nres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT; ptag_ff <= '0; lacc_ff <= '0; lleft_ff <= '0;
         bcnt_ff <= '0; hsh_ff <= '0; brem_ff <= '0; atag_ff <= '0; aleft_ff <= '0;
         cur_ff <= '0; sv_ff <= '0; oc_ff <= '0;
         for (int i = 0; i < S; i++) begin sph_ff[i] <= 2'd0; sst_ff[i] <= 8'd0; end
      end else begin
         phase_ff <= phase_in; ptag_ff <= ptag_in; lacc_ff <= lacc_in;
         lleft_ff <= lleft_in; bcnt_ff <= bcnt_in; hsh_ff <= hsh_in; brem_ff <= brem_in;
         atag_ff <= atag_in; aleft_ff <= aleft_in; cur_ff <= cur_in; sv_ff <= sv_in;
         sph_ff <= sph_in; sst_ff <= sst_in; oc_ff <= oc_in;
      end
      ob_ff <= ob_in;
   end

   a_ob: assert property (@(posedge clock) disable iff (reset) oc_ff <= 2'd3)
      else $error("output buffer overflow");
   a_slot0: assert property (@(posedge clock) disable iff (reset) !sv_ff[S-1])
      else $error("last slot used");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      go && q_data.opcode == csld_pkg::OP_CLEAR |=> sv_ff == '0)
      else $error("clear left sessions");
endmodule

// File: sv/ci_session_layer_deframer_unit.sv
`timescale 1ns / 1ps
// session-layer deframer: takes one request per cycle, back to back, while req_stall is low
// a request reaches its first result through the input queue register, then the parser into the output buffer register
// one request per cycle unless a queue is full; a request giving two results fills two output buffer entries
// the session table's free and close search is a combinational priority encoder
// reset: synchronous active high, clears parser, session table and both queues
module ci_session_layer_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [15:0] req_total_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_session_number,
   output logic [7:0]  rsp_status,
   output logic [31:0] rsp_value,
   output logic [15:0] rsp_apdu_length,
   output logic [1:0]  rsp_session_state,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);
   logic q_valid, q_stall;
   csld_pkg::req_type q_data;
   csld_pkg::rsp_type r;

   csld_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_data_byte,
      .req_first_byte, .req_total_length, .q_valid, .q_stall, .q_data
   );
   csld_back u_back (
      .clock, .reset, .q_valid, .q_stall, .q_data, .rsp_valid, .rsp_stall,
      .rsp_data(r)
   );

   assign rsp_event_res = r.event_res;
   assign rsp_session_number = r.session_number;
   assign rsp_status = r.status;
   assign rsp_value = r.value;
   assign rsp_apdu_length = r.apdu_length;
   assign rsp_session_state = r.session_state;
   assign rsp_error_code = r.error_code;
   assign rsp_last = r.last;
endmodule

// File: test/ci_session_layer_deframer_unit_test.sv
`timescale 1ns / 1ps
module ci_session_layer_deframer_unit_test;
   localparam int PH_WAIT = 0, PH_LEN = 1, PH_LEN_MORE = 2, PH_BODY = 3, PH_ATAG = 4,
      PH_ALEN = 5, PH_ALEN_MORE = 6, PH_ABODY = 7, PH_DISCARD = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_opcode = csld_pkg::OP_BYTE;
   logic [7:0]  req_data_byte = 0;
   logic        req_first_byte = 0;
   logic [15:0] req_total_length = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_event_res;
   logic [3:0]  rsp_session_number;
   logic [7:0]  rsp_status;
   logic [31:0] rsp_value;
   logic [15:0] rsp_apdu_length;
   logic [1:0]  rsp_session_state;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;

   ci_session_layer_deframer_unit dut (.*);

   always #10 clock = ~clock;

   class deframer_scoreboard_type;
      csld_pkg::rsp_type pending[$];
      int mismatches = 0;
      int phase, ptag, len_acc, len_left, body_cnt, bytes_rem, cur_sn;
      int hdr;
      int atag, abytes_left;
      bit      sv_valid[csld_pkg::SLOTS];
      bit [1:0] sv_phase[csld_pkg::SLOTS];
      bit [7:0] sv_status[csld_pkg::SLOTS];
      csld_pkg::rsp_type batch[$];

      function void clear_all();
         phase = PH_WAIT; ptag = 0; len_acc = 0; len_left = 0; body_cnt = 0;
         bytes_rem = 0; cur_sn = 0; hdr = 0; atag = 0; abytes_left = 0;
         foreach (sv_valid[i]) begin
            sv_valid[i] = 0; sv_phase[i] = 0; sv_status[i] = 0;
         end
      endfunction

      function void put(logic [2:0] ev, int sn, int st, logic [31:0] val, int alen,
                        int sst, logic [2:0] err);
         csld_pkg::rsp_type r;
         r.event_res = ev; r.session_number = 4'(sn); r.status = 8'(st); r.value = val;
         r.apdu_length = 16'(alen); r.session_state = 2'(sst); r.error_code = err;
         r.last = 1'b0;
         batch.push_back(r);
      endfunction

      function void enter_atag();
         phase = PH_ATAG; atag = 0; body_cnt = 0;
      endfunction

      // 0 more needed, 1 done, 2 too long
      function int length_byte(int b, int more_phase);
         if (phase == more_phase) begin
            if (len_acc > 'hFF) len_acc = 'hFFFF;
            else len_acc = (len_acc << 8) | b;
            len_left = (len_left - 1) & 'h7F;
            return len_left == 0;
         end
         len_acc = 0;
         if (!b[7]) begin
            len_acc = b;
            return 1;
         end
         if ((b & 'h7F) > csld_pkg::MAX_LEN_BYTES) return 2;
         if ((b & 'h7F) == 0) return 1;
         len_left = b & 'h7F;
         phase = more_phase;
         return 0;
      endfunction

      function int cur_state();
         if (cur_sn == 0 || cur_sn >= csld_pkg::SLOTS) return 0;
         return sv_phase[cur_sn - 1];
      endfunction

      function void decide();
         int i, sn, st;
         logic [31:0] id;
         if (ptag == csld_pkg::TAG_OPEN) begin
            sn = 0;
            id = hdr;
            for (i = 0; i + 1 < csld_pkg::SLOTS; i++) if (!sv_valid[i]) break;
            if (i + 1 >= csld_pkg::SLOTS) st = csld_pkg::ST_FULL;
            else if (id == 32'h00010041 || id == 32'h00020041 || id == 32'h00030041 ||
                     id == 32'h00240041 || id == 32'h00400041) begin
               sv_valid[i] = 1; sv_phase[i] = 1; sv_status[i] = 0;
               sn = i + 1; st = 0;
            end else st = csld_pkg::ST_UNKNOWN;
            put(csld_pkg::EV_OPEN, sn, st, id, 0, sn ? 1 : 0, csld_pkg::ERR_NONE);
            if (sn) begin
               cur_sn = sn; enter_atag();
            end else begin
               if (bytes_rem > 0)
                  put(csld_pkg::EV_ERROR, 0, 0, 0, 0, 0, csld_pkg::ERR_LEN);
               phase = PH_DISCARD;
            end
            return;
         end
         sn = hdr & 'hFFFF;
         if (sn == 0 || sn >= csld_pkg::SLOTS) begin
            phase = PH_DISCARD;
            put(csld_pkg::EV_ERROR, 0, 0, 0, 0, 0, csld_pkg::ERR_BAD_SN);
            return;
         end
         i = sn - 1;
         if (!sv_valid[i]) begin
            phase = PH_DISCARD;
            put(csld_pkg::EV_ERROR, sn, 0, 0, 0, 0, csld_pkg::ERR_CLOSED);
            return;
         end
         if (ptag == csld_pkg::TAG_CREATE) begin
            sv_status[i] = 8'(atag); sv_phase[i] = 1;
            put(csld_pkg::EV_STATE, sn, sv_status[i], 0, 0, 1, csld_pkg::ERR_NONE);
         end else if (ptag == csld_pkg::TAG_CLOSE) begin
            sv_phase[i] = 2;
            put(csld_pkg::EV_STATE, sn, sv_status[i], 0, 0, 2, csld_pkg::ERR_NONE);
         end else if (ptag != csld_pkg::TAG_DATA) begin
            phase = PH_DISCARD;
            put(csld_pkg::EV_ERROR, sn, 0, 0, 0, 0, csld_pkg::ERR_TAG);
            return;
         end
         cur_sn = sn;
         enter_atag();
      endfunction

      function void packet_byte(int b, bit first, int total);
         int r, alen;
         if (first) begin
            ptag = b; bytes_rem = total ? total - 1 : 0; phase = PH_LEN;
            hdr = 0; body_cnt = 0; atag = 0; len_acc = 0; len_left = 0;
         end else begin
            if (phase == PH_WAIT) return;
            if (bytes_rem > 0) bytes_rem--;
            case (phase)
               PH_LEN, PH_LEN_MORE: begin
                  r = length_byte(b, PH_LEN_MORE);
                  if (r == 2) begin
                     phase = PH_DISCARD;
                     put(csld_pkg::EV_ERROR, 0, 0, 0, 0, 0, csld_pkg::ERR_LONG_LEN);
                  end else if (r == 1) begin
                     body_cnt = 0; hdr = 0; atag = 0;
                     if (len_acc == 0) decide();
                     else phase = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (body_cnt == 0) atag = b;
                  if (ptag == csld_pkg::TAG_OPEN) begin
                     if (body_cnt < 4) hdr = hdr | (b << (24 - 8 * body_cnt));
                  end else hdr = (hdr << 8) | b;
                  body_cnt = (body_cnt + 1) & 'hFFFF;
                  if (body_cnt == len_acc) decide();
               end
               PH_ATAG: begin
                  atag = ((atag << 8) | b) & 'hFFFFFF;
                  body_cnt++;
                  if (body_cnt >= 3) begin
                     phase = PH_ALEN; len_acc = 0;
                  end
               end
               PH_ALEN, PH_ALEN_MORE: begin
                  r = length_byte(b, PH_ALEN_MORE);
                  if (r == 2) begin
                     phase = PH_DISCARD;
                     put(csld_pkg::EV_ERROR, cur_sn, 0, 0, 0, cur_state(),
                         csld_pkg::ERR_LONG_LEN);
                  end else if (r == 1) begin
                     alen = len_acc;
                     // short-tail workaround
                     if (bytes_rem > alen && bytes_rem - alen < 3) alen = bytes_rem;
                     put(csld_pkg::EV_AHDR, cur_sn, 0, atag, alen, cur_state(),
                         csld_pkg::ERR_NONE);
                     abytes_left = alen;
                     if (alen == 0) enter_atag();
                     else phase = PH_ABODY;
                  end
               end
               PH_ABODY: begin
                  put(csld_pkg::EV_ABYTE, cur_sn, 0, b, 0, cur_state(), csld_pkg::ERR_NONE);
                  abytes_left = (abytes_left - 1) & 'hFFFF;
                  if (abytes_left == 0) enter_atag();
               end
               default: ;
            endcase
         end
         if (phase != PH_WAIT && bytes_rem == 0) begin
            if (!(phase == PH_DISCARD || (phase == PH_ATAG && body_cnt == 0)))
               put(csld_pkg::EV_ERROR, 0, 0, 0, 0, 0, csld_pkg::ERR_LEN);
            phase = PH_WAIT;
         end
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] b, logic first,
                                 logic [15:0] total);
         int i;
         batch.delete();
         if (op == csld_pkg::OP_BYTE) packet_byte(int'(b), first, int'(total));
         else if (op == csld_pkg::OP_POLL) begin
            for (i = 0; i + 1 < csld_pkg::SLOTS; i++)
               if (sv_valid[i] && sv_phase[i] == 2) break;
            if (i + 1 < csld_pkg::SLOTS) begin
               sv_valid[i] = 0; sv_phase[i] = 0; sv_status[i] = 0;
               put(csld_pkg::EV_CLOSE, i + 1, 0, 32'(csld_pkg::TAG_CLOSE_RSP), 0, 2,
                   csld_pkg::ERR_NONE);
            end else put(csld_pkg::EV_IDLE, 0, 0, 0, 0, 0, csld_pkg::ERR_NONE);
         end else if (op == csld_pkg::OP_CLEAR) begin
            foreach (sv_valid[j]) begin
               sv_valid[j] = 0; sv_phase[j] = 0; sv_status[j] = 0;
            end
            phase = PH_WAIT; cur_sn = 0;
            put(csld_pkg::EV_IDLE, 0, 0, 0, 0, 0, csld_pkg::ERR_NONE);
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[k]) pending.push_back(batch[k]);
      endfunction

      function void check_result(csld_pkg::rsp_type got);
         csld_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   deframer_scoreboard_type board = new();
   int cycles = 0;
   int sent = 0;
   bit calm = 0;
   int rsp_idle_left = 0;

   always @(posedge clock) begin
      csld_pkg::rsp_type got;
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_event_res, rsp_session_number, rsp_status, rsp_value,
                 rsp_apdu_length, rsp_session_state, rsp_error_code, rsp_last};
         board.check_result(got);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (calm) rsp_stall <= 0;
      else if (rsp_idle_left > 0) begin
         rsp_idle_left--;
         rsp_stall <= 1;
      end else if ($urandom_range(9) == 0) begin
         rsp_idle_left = $urandom_range(7);
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send(logic [1:0] op, logic [7:0] b, logic first, logic [15:0] total);
      if (!calm && $urandom_range(9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1; req_opcode <= op; req_data_byte <= b;
      req_first_byte <= first; req_total_length <= total;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(op, b, first, total);
      sent++;
      @(negedge clock);
   endtask

   // one whole packet: tag, length, body, then apdus
   task automatic send_packet(logic [7:0] tag, byte unsigned body[$]);
      int total;
      total = body.size() + 1;
      send(csld_pkg::OP_BYTE, tag, 1'b1, 16'(total));
      foreach (body[i]) send(csld_pkg::OP_BYTE, body[i], 1'b0, 16'd0);
   endtask

   task automatic random_packet();
      byte unsigned body[$];
      int kind, n, sn;
      logic [7:0] tag;
      logic [31:0] ids[5] = '{32'h00010041, 32'h00020041, 32'h00030041,
                              32'h00240041, 32'h00400041};
      logic [31:0] id;
      kind = $urandom_range(9);
      sn = $urandom_range(0, 15);
      if (kind < 3) begin
         tag = csld_pkg::TAG_OPEN;
         id = ($urandom_range(4) == 0) ? 32'($urandom) : ids[$urandom_range(4)];
         body.push_back(8'd4);
         for (int k = 3; k >= 0; k--) body.push_back(id[8*k +: 8]);
      end else begin
         tag = (kind < 5) ? csld_pkg::TAG_DATA : (kind < 7) ? csld_pkg::TAG_CREATE :
               (kind < 8) ? csld_pkg::TAG_CLOSE : 8'($urandom);
         if (tag == csld_pkg::TAG_CREATE) begin
            body.push_back(8'd3); body.push_back(8'($urandom));
         end else body.push_back(8'd2);
         body.push_back(8'd0); body.push_back(8'(sn));
      end
      // apdus
      repeat ($urandom_range(0, 2)) begin
         n = $urandom_range(0, 4);
         body.push_back(8'($urandom)); body.push_back(8'($urandom));
         body.push_back(8'($urandom));
         if ($urandom_range(5) == 0) begin
            body.push_back(8'h81); body.push_back(8'(n));
         end else if ($urandom_range(7) == 0) begin
            body.push_back(8'h82); body.push_back(8'd0); body.push_back(8'(n));
         end else body.push_back(8'(n));
         repeat (n) body.push_back(8'($urandom));
      end
      // broken sequences now and then
      if ($urandom_range(7) == 0 && body.size() > 1) body.pop_back();
      if ($urandom_range(9) == 0) body.push_back(8'($urandom));
      if ($urandom_range(11) == 0) body[0] = 8'($urandom);
      send_packet(tag, body);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      board.clear_all();
      // directed
      send(csld_pkg::OP_BYTE, 8'h55, 1'b0, 16'd0);     // stray byte, ignored
      send(csld_pkg::OP_UNDEF, 8'hFF, 1'b1, 16'hFFFF);
      send_packet(csld_pkg::TAG_OPEN, {4, 0, 1, 0, 8'h41, 8'h9F, 8'h80, 8'h10, 2,
                                       8'hAA, 8'h55});
      send_packet(csld_pkg::TAG_OPEN, {4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1});
      send_packet(csld_pkg::TAG_CREATE, {3, 8'h7E, 0, 1});
      send(csld_pkg::OP_BYTE, csld_pkg::TAG_DATA, 1'b1, 16'hFFFF);
      send(csld_pkg::OP_BYTE, 8'h83, 1'b0, 16'd0);     // long length
      send_packet(csld_pkg::TAG_CLOSE, {2, 0, 1});
      send_packet(csld_pkg::TAG_DATA, {2, 0, 0});
      send_packet(csld_pkg::TAG_DATA, {2, 0, 9});
      send_packet(8'h33, {2, 0, 1});
      send(csld_pkg::OP_POLL, 8'd0, 1'b0, 16'd0);
      send(csld_pkg::OP_POLL, 8'd0, 1'b0, 16'd0);
      send_packet(csld_pkg::TAG_OPEN, {8'h82, 0});
      send(csld_pkg::OP_BYTE, csld_pkg::TAG_OPEN, 1'b1, 16'd0);   // tag mid packet
      send(csld_pkg::OP_CLEAR, 8'd0, 1'b0, 16'd0);
      while (sent < 1250) begin
         if ($urandom_range(14) == 0) begin
            send(csld_pkg::OP_POLL, 8'd0, 1'b0, 16'd0);
         end else if ($urandom_range(60) == 0) begin
            send(csld_pkg::OP_CLEAR, 8'd0, 1'b0, 16'd0);
         end else if ($urandom_range(20) == 0) begin
            send(2'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
         end else begin
            random_packet();
         end
         if (sent > 1000) calm = 1;
      end
      req_valid <= 1'b0;
      while (board.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
